@@ hdl/hs2i_pkg.sv @@
// Shared types, character codes, event codes and helper functions for the hex serial to I2C bridge.
package hs2i_pkg;

	// Default transmit buffer depth and the most result words one input word can cause
	localparam int unsigned BufDepthDef = 256;
	localparam int unsigned MaxRes      = 6;
	localparam int unsigned CntW        = $clog2(MaxRes + 1);

	// I2C controller event codes, as renumbered on the event port
	localparam logic [3:0] EV_BUS_ERROR  = 4'd0;
	localparam logic [3:0] EV_SLAVE_ADDR = 4'd1;
	localparam logic [3:0] EV_SLAVE_DATA = 4'd2;
	localparam logic [3:0] EV_SLAVE_STOP = 4'd3;
	localparam logic [3:0] EV_START      = 4'd4;
	localparam logic [3:0] EV_MT_ACK     = 4'd5;
	localparam logic [3:0] EV_ARB_LOST   = 4'd6;
	localparam logic [3:0] EV_REP_START  = 4'd7;
	localparam logic [3:0] EV_MR_DATA    = 4'd8;
	localparam logic [3:0] EV_MR_SLA_ACK = 4'd9;
	localparam logic [3:0] EV_MR_SLA_NAK = 4'd10;
	localparam logic [3:0] EV_MR_LAST    = 4'd11;

	// Characters of the serial protocol
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_S     = 8'h73;

	// Read/write bit of an I2C address byte
	localparam logic [7:0] TW_READ = 8'h01;

	// One result word: a serial character or a controller command
	typedef struct packed {
		logic       kind;
		logic [7:0] ch;
		logic       sta;
		logic       sto;
		logic       ea;
		logic       ld;
		logic [7:0] data;
	} res_t;

	// Architectural state of the bridge, apart from the transmit buffer
	typedef struct packed {
		logic [7:0] send_count;
		logic [7:0] read_count;
		logic [7:0] byte_pos;
		logic [7:0] held_char;
		logic       expect_first;
		logic       expect_length;
		logic       transfer_pending;
		logic       reply_pending;
		logic       bus_busy;
	} st_t;

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		logic [7:0] c;
		if (v < 4'd10) c = 8'h30 + {4'd0, v};
		else           c = 8'h37 + {4'd0, v};
		return c;
	endfunction

	// Decodes one hex digit of either case; anything else reads as zero
	function automatic logic [3:0] nibble(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39)      v = 4'(c - 8'h30);
		else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
		else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
		return v;
	endfunction

	function automatic res_t mk_char(input logic [7:0] c);
		res_t r;
		r      = '0;
		r.kind = 1'b0;
		r.ch   = c;
		return r;
	endfunction

	function automatic res_t mk_cmd(input logic sta, input logic sto, input logic ea,
			input logic ld, input logic [7:0] d);
		res_t r;
		r      = '0;
		r.kind = 1'b1;
		r.sta  = sta;
		r.sto  = sto;
		r.ea   = ea;
		r.ld   = ld;
		r.data = ld ? d : 8'd0;
		return r;
	endfunction

endpackage

@@ hdl/hs2i_step.sv @@
// Next-state and result-list logic for one input word of the bridge.
module hs2i_step #(
	parameter int unsigned BUF_DEPTH = hs2i_pkg::BufDepthDef
) (
	input  logic                       op,
	input  logic [7:0]                 rx_byte,
	input  logic [3:0]                 twi_event,
	input  logic [7:0]                 twi_data,
	input  logic [7:0]                 rd_data,
	input  hs2i_pkg::st_t              st,
	output hs2i_pkg::st_t              st_nxt,
	output hs2i_pkg::res_t             res [hs2i_pkg::MaxRes],
	output logic [hs2i_pkg::CntW-1:0]  res_cnt,
	output logic                       wr_en,
	output logic [7:0]                 wr_data
);
	import hs2i_pkg::*;

	logic [CntW-1:0] n;
	logic [7:0]      bp_mt;
	logic [7:0]      bp_inc;
	logic [8:0]      sc_inc;
	logic            final_rd;

	always_comb begin
		n       = '0;
		for (int i = 0; i < MaxRes; i++) res[i] = '0;
		st_nxt  = st;
		wr_en   = 1'b0;
		wr_data = {nibble(st.held_char), nibble(rx_byte)};
		bp_mt   = (twi_event == EV_START) ? 8'd0 : st.byte_pos;
		bp_inc  = st.byte_pos + 8'd1;
		sc_inc  = {1'b0, st.send_count} + 9'd1;
		final_rd = 1'b0;

		if (!op) begin
			if (st.expect_first) begin
				st_nxt.held_char = rx_byte;
				if (rx_byte == CH_DOT) begin
					st_nxt.reply_pending = 1'b1;
				end else if (rx_byte == CH_SPACE) begin
					st_nxt.transfer_pending = 1'b1;
					st_nxt.expect_length    = 1'b1;
				end else begin
					st_nxt.expect_first = 1'b0;
				end
			end else begin
				st_nxt.expect_first = 1'b1;
				if (st.expect_length) begin
					st_nxt.expect_length = 1'b0;
					st_nxt.read_count    = wr_data;
				end else begin
					wr_en = 1'b1;
					st_nxt.send_count = (sc_inc == 9'(BUF_DEPTH)) ? 8'd0 : sc_inc[7:0];
				end
			end
		end else begin
			unique case (twi_event) inside
				EV_BUS_ERROR: begin
					res[n] = mk_cmd(1'b0, 1'b1, 1'b1, 1'b0, 8'd0); n = n + CntW'(1);
				end
				EV_SLAVE_ADDR: begin
					st_nxt.bus_busy = 1'b1;
					res[n] = mk_cmd(1'b0, 1'b0, 1'b1, 1'b0, 8'd0); n = n + CntW'(1);
				end
				EV_SLAVE_DATA: begin
					res[n] = mk_char(hex_char(twi_data[7:4])); n = n + CntW'(1);
					res[n] = mk_char(hex_char(twi_data[3:0])); n = n + CntW'(1);
					res[n] = mk_cmd(1'b0, 1'b0, 1'b1, 1'b0, 8'd0); n = n + CntW'(1);
				end
				EV_SLAVE_STOP: begin
					res[n] = mk_char(CH_CR); n = n + CntW'(1);
					res[n] = mk_char(CH_LF); n = n + CntW'(1);
					st_nxt.bus_busy = 1'b0;
					res[n] = mk_cmd(1'b0, 1'b0, 1'b1, 1'b0, 8'd0); n = n + CntW'(1);
				end
				EV_START, EV_MT_ACK: begin
					if (twi_event == EV_START) st_nxt.bus_busy = 1'b1;
					st_nxt.byte_pos = bp_mt;
					if (bp_mt == st.send_count) begin
						if (st.reply_pending) begin
							res[n] = mk_cmd(1'b1, 1'b0, 1'b1, 1'b0, 8'd0); n = n + CntW'(1);
							st_nxt.reply_pending = 1'b0;
						end else begin
							res[n] = mk_cmd(1'b0, 1'b1, 1'b1, 1'b0, 8'd0); n = n + CntW'(1);
							st_nxt.bus_busy = 1'b0;
						end
						st_nxt.send_count = 8'd0;
					end else begin
						res[n] = mk_cmd(1'b0, 1'b0, 1'b1, 1'b1, rd_data); n = n + CntW'(1);
						st_nxt.byte_pos = bp_mt + 8'd1;
					end
				end
				EV_ARB_LOST: begin
					st_nxt.bus_busy = 1'b0;
					res[n] = mk_cmd(1'b0, 1'b0, 1'b1, 1'b0, 8'd0); n = n + CntW'(1);
				end
				EV_REP_START: begin
					st_nxt.bus_busy = 1'b1;
					res[n] = mk_cmd(1'b0, 1'b0, 1'b1, 1'b1, rd_data | TW_READ);
					n = n + CntW'(1);
					res[n] = mk_char(CH_S); n = n + CntW'(1);
					st_nxt.byte_pos = 8'd0;
				end
				EV_MR_DATA: begin
					res[n] = mk_char(hex_char(twi_data[7:4])); n = n + CntW'(1);
					res[n] = mk_char(hex_char(twi_data[3:0])); n = n + CntW'(1);
					st_nxt.byte_pos = bp_inc;
					final_rd = (st.read_count != 8'd0) && (bp_inc == st.read_count - 8'd1);
					res[n] = mk_cmd(1'b0, 1'b0, !final_rd, 1'b0, 8'd0); n = n + CntW'(1);
				end
				EV_MR_SLA_ACK: begin
					final_rd = (st.read_count != 8'd0)
						&& (st.byte_pos == st.read_count - 8'd1);
					res[n] = mk_cmd(1'b0, 1'b0, !final_rd, 1'b0, 8'd0); n = n + CntW'(1);
				end
				EV_MR_SLA_NAK: begin
					res[n] = mk_cmd(1'b0, 1'b1, 1'b1, 1'b0, 8'd0); n = n + CntW'(1);
					st_nxt.bus_busy = 1'b0;
					res[n] = mk_char(CH_CR); n = n + CntW'(1);
					res[n] = mk_char(CH_LF); n = n + CntW'(1);
				end
				EV_MR_LAST: begin
					res[n] = mk_char(hex_char(twi_data[7:4])); n = n + CntW'(1);
					res[n] = mk_char(hex_char(twi_data[3:0])); n = n + CntW'(1);
					res[n] = mk_char(CH_CR); n = n + CntW'(1);
					res[n] = mk_char(CH_LF); n = n + CntW'(1);
					st_nxt.byte_pos = bp_inc;
					res[n] = mk_cmd(1'b0, 1'b1, 1'b1, 1'b0, 8'd0); n = n + CntW'(1);
					st_nxt.bus_busy = 1'b0;
				end
				default: begin
				end
			endcase
		end

		// A pending transfer starts as soon as the bus is seen idle.
		if (st_nxt.transfer_pending && !st_nxt.bus_busy) begin
			res[n] = mk_cmd(1'b1, 1'b0, 1'b1, 1'b0, 8'd0); n = n + CntW'(1);
			st_nxt.transfer_pending = 1'b0;
		end

		res_cnt = n;
	end

endmodule

@@ hdl/hs2i_outq.sv @@
// Result queue: holds the result words of one input word and hands them out one per cycle while out_ready is high.
module hs2i_outq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  hs2i_pkg::res_t             load_res [hs2i_pkg::MaxRes],
	input  logic [hs2i_pkg::CntW-1:0]  load_cnt,
	output logic                       load_ok,
	output logic                       out_valid,
	input  logic                       out_ready,
	output hs2i_pkg::res_t             head,
	output logic                       head_last
);
	import hs2i_pkg::*;

	res_t            res_q [MaxRes];
	logic [CntW-1:0] cnt_q;
	logic            pop;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign load_ok   = (cnt_q == '0) || (cnt_q == CntW'(1) && out_ready);
	assign head      = res_q[0];
	assign head_last = (cnt_q == CntW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= load_cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - CntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= load_res;
		end else if (pop) begin
			for (int i = 0; i < MaxRes - 1; i++) res_q[i] <= res_q[i + 1];
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(MaxRes))
		else $error("result count above the queue depth");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(load && load_cnt != '0) |=> out_valid)
		else $error("loaded results not presented");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(!load && pop) |=> (cnt_q == $past(cnt_q) - CntW'(1)))
		else $error("queue count did not step down on a taken word");

endmodule

@@ hdl/hex_serial_to_i2c_bridge.sv @@
// Top level of the hex serial to I2C bridge: input register, transmit buffer, state and result queue.
// The first result word of an input word is offered from the result queue, after stage one has worked the word out.
// Throughput: one input word per cycle while each causes at most one result word and out_ready is high;
// otherwise a new word waits while the result queue hands out the results (up to six) singly.
// Reset (arst_n low, asynchronous) clears the parser and bus state and empties both stages;
// the transmit buffer is not cleared and holds nothing defined until written.
module hex_serial_to_i2c_bridge #(
	parameter int unsigned BUF_DEPTH = hs2i_pkg::BufDepthDef
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       op,
	input  logic [7:0] rx_byte,
	input  logic [3:0] twi_event,
	input  logic [7:0] twi_data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       kind,
	output logic [7:0] out_char,
	output logic       send_start,
	output logic       send_stop,
	output logic       ack_enable,
	output logic       load_data,
	output logic [7:0] data_byte,
	output logic       last
);
	import hs2i_pkg::*;

	// Address width of the transmit buffer
	localparam int unsigned AW = $clog2(BUF_DEPTH);

	// Stage one holds the accepted word together with the buffer entry it needs.
	logic       valid_s1;
	logic       op_s1;
	logic [7:0] rxb_s1;
	logic [3:0] ev_s1;
	logic [7:0] twd_s1;
	logic [7:0] rd_s1;

	st_t             st_q;
	st_t             st_nxt;
	res_t            step_res [MaxRes];
	logic [CntW-1:0] step_cnt;
	logic            step_we;
	logic [7:0]      step_wd;

	logic            q_load_ok;
	logic            s1_fire;
	logic            in_acc;
	res_t            head;
	logic            head_last;

	logic [7:0]      mem [BUF_DEPTH];
	logic [AW-1:0]   mod_tbl [256];
	logic [7:0]      bp_sel;
	logic [AW-1:0]   rd_addr;
	logic [AW-1:0]   wr_addr;
	logic            wr_en;

	// The word in stage one is worked out in the cycle that the queue can take all its results,
	// so a new word may enter in that same cycle.
	assign s1_fire  = valid_s1 && q_load_ok;
	assign in_ready = !valid_s1 || s1_fire;
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1  <= op;
			rxb_s1 <= rx_byte;
			ev_s1  <= twi_event;
			twd_s1 <= twi_data;
		end
	end

	// Bridge state moves on only when the word in stage one is worked out.
	// After reset all counts are zero and the parser waits for the first character of a
	// read length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= {8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0};
		end else if (s1_fire) begin
			st_q <= st_nxt;
		end
	end

	// Byte position folded into the buffer depth. For a power-of-two depth this is a plain mask;
	// otherwise the constant table does the reduction.
	for (genvar g = 0; g < 256; g++) begin : g_mod
		assign mod_tbl[g] = AW'(g % BUF_DEPTH);
	end

	// The buffer is read as the word is accepted. Only a transmit acknowledge reads at the byte
	// position; a start reads entry zero because the position restarts there, and a repeated
	// start always sends entry zero as the read address. The position is taken after the word
	// now leaving stage one, since that word updates the state at this very edge.
	assign bp_sel  = s1_fire ? st_nxt.byte_pos : st_q.byte_pos;
	assign rd_addr = (op && twi_event == EV_MT_ACK) ? mod_tbl[bp_sel] : '0;

	// The fill count never reaches the depth, so its low bits address the buffer directly.
	assign wr_addr = st_q.send_count[AW-1:0];
	assign wr_en   = s1_fire && step_we;

	// A write from the leaving word and a read for the arriving word may meet at one entry;
	// the written byte is then passed straight to the read register.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= step_wd;
		end
		if (in_acc) begin
			rd_s1 <= (wr_en && wr_addr == rd_addr) ? step_wd : mem[rd_addr];
		end
	end

	hs2i_step #(
		.BUF_DEPTH (BUF_DEPTH)
	) u_step (
		.op        (op_s1),
		.rx_byte   (rxb_s1),
		.twi_event (ev_s1),
		.twi_data  (twd_s1),
		.rd_data   (rd_s1),
		.st        (st_q),
		.st_nxt    (st_nxt),
		.res       (step_res),
		.res_cnt   (step_cnt),
		.wr_en     (step_we),
		.wr_data   (step_wd)
	);

	hs2i_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (s1_fire),
		.load_res  (step_res),
		.load_cnt  (step_cnt),
		.load_ok   (q_load_ok),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head),
		.head_last (head_last)
	);

	assign kind       = head.kind;
	assign out_char   = head.ch;
	assign send_start = head.sta;
	assign send_stop  = head.sto;
	assign ack_enable = head.ea;
	assign load_data  = head.ld;
	assign data_byte  = head.data;
	assign last       = head_last;

	// The fill count must stay inside the buffer for the write address to be right.
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		9'(st_q.send_count) < 9'(BUF_DEPTH))
		else $error("fill count outside the transmit buffer");

	// A start restarts transmission, so at most one byte can have gone out after it.
	a_start_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && op_s1 && ev_s1 == EV_START) |=> (st_q.byte_pos <= 8'd1))
		else $error("byte position not restarted by a start event");

	// A repeated start always leaves the bus marked as taken.
	a_rep_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && op_s1 && ev_s1 == EV_REP_START) |=> st_q.bus_busy)
		else $error("bus not marked busy after a repeated start");

endmodule

@@ tb/sv/hex_serial_to_i2c_bridge_tb.sv @@
// Self-checking testbench for the hex serial to I2C bridge: directed commands, wrap cases and random traffic.
module hex_serial_to_i2c_bridge_tb;
	import hs2i_pkg::*;

	// The run is stopped by force if it goes on far beyond what the slowest correct run needs.
	localparam int CYCLE_LIMIT = 400000;
	// The bridge ignores event codes from twelve upwards; this is the one used on purpose.
	localparam logic [3:0] EV_NO_EVENT = 4'd12;
	// Cycles to wait after the last expected word, well beyond the bridge latency.
	localparam int DRAIN_CYCLES = 20;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic       op;
	logic [7:0] rx_byte;
	logic [3:0] twi_event;
	logic [7:0] twi_data;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       kind;
	logic [7:0] out_char;
	logic       send_start;
	logic       send_stop;
	logic       ack_enable;
	logic       load_data;
	logic [7:0] data_byte;
	logic       last;

	hex_serial_to_i2c_bridge DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.rx_byte    (rx_byte),
		.twi_event  (twi_event),
		.twi_data   (twi_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.out_char   (out_char),
		.send_start (send_start),
		.send_stop  (send_stop),
		.ack_enable (ack_enable),
		.load_data  (load_data),
		.data_byte  (data_byte),
		.last       (last)
	);

	always #4 clk = ~clk;

	// One expected output word together with its end-of-input marker.
	typedef struct packed {
		res_t word;
		logic is_last;
	} awaited_word_t;

	// Our own view of the bridge state; the transmit buffer is kept apart below.
	typedef struct packed {
		logic [7:0] fill_cnt;
		logic [7:0] rd_len;
		logic [7:0] pos;
		logic [7:0] held;
		logic       want_first;
		logic       want_len;
		logic       go_pending;
		logic       rs_pending;
		logic       busy;
	} bridge_state_t;

	bridge_state_t bridge;
	logic [7:0]    tx_buf [256];
	// Entries of the transmit buffer that have been written; the bridge holds
	// nothing defined elsewhere, so the stimulus must never make it read one.
	bit            tx_written [256];

	res_t          step_words[$];
	awaited_word_t awaited_words[$];
	awaited_word_t head_word;

	int  fail_count     = 0;
	int  words_sent     = 0;
	int  results_seen   = 0;
	int  cycle_count    = 0;
	int  ready_hold     = 0;
	bit  gaps_on        = 1'b0;
	bit  stalls_on      = 1'b0;

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Hex digit as text; the bridge itself always echoes upper case.
	function automatic logic [7:0] hex_text(input logic [3:0] v, input bit lower);
		if (v < 4'd10)
			return 8'h30 + {4'd0, v};
		return (lower ? 8'h57 : 8'h37) + {4'd0, v};
	endfunction

	// Any character that is not a hex digit of either case counts as zero.
	function automatic logic [3:0] decode_hex(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return 4'(c - "0");
		if (c >= "A" && c <= "F")
			return 4'(c - "A" + 10);
		if (c >= "a" && c <= "f")
			return 4'(c - "a" + 10);
		return 4'd0;
	endfunction

	function automatic void add_char(input logic [7:0] c);
		res_t r;
		r      = '0;
		r.kind = 1'b0;
		r.ch   = c;
		step_words.push_back(r);
	endfunction

	function automatic void add_cmd(input logic sta, input logic sto, input logic ea,
			input logic ld, input logic [7:0] d);
		res_t r;
		r      = '0;
		r.kind = 1'b1;
		r.sta  = sta;
		r.sto  = sto;
		r.ea   = ea;
		r.ld   = ld;
		r.data = ld ? d : 8'd0;
		step_words.push_back(r);
	endfunction

	function automatic void add_echo(input logic [7:0] d);
		add_char(hex_text(d[7:4], 1'b0));
		add_char(hex_text(d[3:0], 1'b0));
	endfunction

	// Master transmitter moves on: next buffered byte, or the end of the write,
	// which becomes a repeated start when a read is waiting.
	function automatic void continue_write();
		if (bridge.pos == bridge.fill_cnt) begin
			if (bridge.rs_pending) begin
				add_cmd(1'b1, 1'b0, 1'b1, 1'b0, 8'd0);
				bridge.rs_pending = 1'b0;
			end else begin
				add_cmd(1'b0, 1'b1, 1'b1, 1'b0, 8'd0);
				bridge.busy = 1'b0;
			end
			bridge.fill_cnt = 8'd0;
		end else begin
			add_cmd(1'b0, 1'b0, 1'b1, 1'b1, tx_buf[bridge.pos]);
			bridge.pos = bridge.pos + 8'd1;
		end
	endfunction

	// A read length of zero never matches, so the acknowledge then stays on.
	function automatic void ack_read();
		logic [7:0] final_pos;
		final_pos = bridge.rd_len - 8'd1;
		add_cmd(1'b0, 1'b0, !(bridge.rd_len != 8'd0 && bridge.pos == final_pos), 1'b0, 8'd0);
	endfunction

	function automatic void reset_bridge();
		bridge            = '0;
		bridge.want_first = 1'b1;
		bridge.want_len   = 1'b1;
		foreach (tx_written[i])
			tx_written[i] = 1'b0;
	endfunction

	// True when this event would make the bridge read a buffer entry never written.
	function automatic bit reads_unwritten(input logic [3:0] ev);
		case (ev)
			EV_START:     return bridge.fill_cnt != 8'd0 && !tx_written[0];
			EV_MT_ACK:    return bridge.pos != bridge.fill_cnt && !tx_written[bridge.pos];
			EV_REP_START: return !tx_written[0];
			default:      return 1'b0;
		endcase
	endfunction

	// Works out the output words of one accepted input word and queues them.
	function automatic void predict_bridge(input logic w_op, input logic [7:0] c,
			input logic [3:0] ev, input logic [7:0] d);
		logic [7:0] v;
		step_words.delete();
		if (!w_op) begin
			if (bridge.want_first) begin
				bridge.held = c;
				if (c == CH_DOT) begin
					bridge.rs_pending = 1'b1;
				end else if (c == CH_SPACE) begin
					bridge.go_pending = 1'b1;
					bridge.want_len   = 1'b1;
				end else begin
					bridge.want_first = 1'b0;
				end
			end else begin
				v = {decode_hex(bridge.held), decode_hex(c)};
				bridge.want_first = 1'b1;
				if (bridge.want_len) begin
					bridge.want_len = 1'b0;
					bridge.rd_len   = v;
				end else begin
					tx_buf[bridge.fill_cnt]     = v;
					tx_written[bridge.fill_cnt] = 1'b1;
					bridge.fill_cnt             = bridge.fill_cnt + 8'd1;
				end
			end
		end else begin
			case (ev)
				EV_BUS_ERROR: add_cmd(1'b0, 1'b1, 1'b1, 1'b0, 8'd0);
				EV_SLAVE_ADDR: begin
					bridge.busy = 1'b1;
					add_cmd(1'b0, 1'b0, 1'b1, 1'b0, 8'd0);
				end
				EV_SLAVE_DATA: begin
					add_echo(d);
					add_cmd(1'b0, 1'b0, 1'b1, 1'b0, 8'd0);
				end
				EV_SLAVE_STOP: begin
					add_char(CH_CR);
					add_char(CH_LF);
					bridge.busy = 1'b0;
					add_cmd(1'b0, 1'b0, 1'b1, 1'b0, 8'd0);
				end
				EV_START: begin
					bridge.pos  = 8'd0;
					bridge.busy = 1'b1;
					continue_write();
				end
				EV_MT_ACK: continue_write();
				EV_ARB_LOST: begin
					bridge.busy = 1'b0;
					add_cmd(1'b0, 1'b0, 1'b1, 1'b0, 8'd0);
				end
				EV_REP_START: begin
					bridge.busy = 1'b1;
					add_cmd(1'b0, 1'b0, 1'b1, 1'b1, tx_buf[0] | TW_READ);
					add_char(CH_S);
					bridge.pos = 8'd0;
				end
				EV_MR_DATA: begin
					add_echo(d);
					bridge.pos = bridge.pos + 8'd1;
					ack_read();
				end
				EV_MR_SLA_ACK: ack_read();
				EV_MR_SLA_NAK: begin
					add_cmd(1'b0, 1'b1, 1'b1, 1'b0, 8'd0);
					bridge.busy = 1'b0;
					add_char(CH_CR);
					add_char(CH_LF);
				end
				EV_MR_LAST: begin
					add_echo(d);
					add_char(CH_CR);
					add_char(CH_LF);
					bridge.pos = bridge.pos + 8'd1;
					add_cmd(1'b0, 1'b1, 1'b1, 1'b0, 8'd0);
					bridge.busy = 1'b0;
				end
				default: ;
			endcase
		end
		// A waiting transfer is kicked off as soon as the bus is seen idle.
		if (bridge.go_pending && !bridge.busy) begin
			add_cmd(1'b1, 1'b0, 1'b1, 1'b0, 8'd0);
			bridge.go_pending = 1'b0;
		end
		foreach (step_words[i])
			awaited_words.push_back('{word: step_words[i], is_last: i == step_words.size() - 1});
	endfunction

	// ------------------------------------------------------------------
	// Driving the input side
	// ------------------------------------------------------------------

	// Offers one word and returns at the edge where it is taken. Valid is only
	// dropped when a gap is inserted, so it never falls and rises in one step.
	task automatic send_word(input logic w_op, input logic [7:0] w_rx,
			input logic [3:0] w_ev, input logic [7:0] w_td);
		logic [3:0] ev;
		ev = w_ev;
		if (w_op && reads_unwritten(ev))
			ev = EV_NO_EVENT;
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		op        <= w_op;
		rx_byte   <= w_rx;
		twi_event <= ev;
		twi_data  <= w_td;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_bridge(w_op, w_rx, ev, w_td);
		words_sent++;
	endtask

	// The unused fields carry random values so that every input bit toggles.
	task automatic send_serial(input logic [7:0] c);
		send_word(1'b0, c, 4'($urandom), 8'($urandom));
	endtask

	task automatic send_event(input logic [3:0] ev, input logic [7:0] d);
		send_word(1'b1, 8'($urandom), ev, d);
	endtask

	// Sends a byte as two hex characters in mixed case; with junk allowed, a
	// digit is now and then replaced by a letter that is not hex.
	task automatic send_hex_pair(input logic [7:0] value, input bit junk_ok);
		logic [7:0] hi;
		logic [7:0] lo;
		hi = hex_text(value[7:4], 1'($urandom));
		lo = hex_text(value[3:0], 1'($urandom));
		if (junk_ok && $urandom_range(0, 11) == 0)
			hi = 8'($urandom_range(8'h47, 8'h5A));
		if (junk_ok && $urandom_range(0, 11) == 0)
			lo = 8'($urandom_range(8'h47, 8'h5A));
		send_serial(hi);
		send_serial(lo);
	endtask

	// ------------------------------------------------------------------
	// Output side: back-pressure and checking
	// ------------------------------------------------------------------

	// Ready drops now and then while stalls are enabled, held low for a random stretch drawn into ready_hold.
	always @(posedge clk) begin
		if (ready_hold != 0) begin
			ready_hold = ready_hold - 1;
			out_ready <= 1'b0;
		end else if (stalls_on && $urandom_range(0, 5) == 0) begin
			ready_hold = $urandom_range(0, 2);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			if (fail_count < 40)
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// Every word taken from the bridge is held against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (awaited_words.size() == 0) begin
				if (fail_count < 40)
					$display("%0t: unexpected word, expected none, got kind %0b char %0h data %0h",
						$time, kind, out_char, data_byte);
				fail_count++;
			end else begin
				head_word = awaited_words.pop_front();
				check_field("kind", 8'(head_word.word.kind), 8'(kind));
				check_field("out_char", head_word.word.ch, out_char);
				check_field("send_start", 8'(head_word.word.sta), 8'(send_start));
				check_field("send_stop", 8'(head_word.word.sto), 8'(send_stop));
				check_field("ack_enable", 8'(head_word.word.ea), 8'(ack_enable));
				check_field("load_data", 8'(head_word.word.ld), 8'(load_data));
				check_field("data_byte", head_word.word.data, data_byte);
				check_field("last", 8'(head_word.is_last), 8'(last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: timeout after %0d cycles", cycle_count);
			$display("tb: failure");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Length capture, a write with mixed-case and invalid digits, the extreme
	// character codes, and a full master write ending in a stop.
	task automatic test_write_command();
		send_serial(CH_SPACE);
		send_serial("0");
		send_serial("3");
		send_serial("a");
		send_serial("B");
		send_serial(8'h00);
		send_serial("G");
		send_serial(8'hFF);
		send_serial("f");
		send_event(EV_START, 8'h00);
		send_event(EV_MT_ACK, 8'hFF);
		send_event(EV_MT_ACK, 8'h55);
		send_event(EV_MT_ACK, 8'hAA);
	endtask

	// A write of the address followed by a repeated-start read with length zero,
	// so every received byte is acknowledged.
	task automatic test_read_command();
		send_serial(CH_DOT);
		send_serial(CH_SPACE);
		send_hex_pair(8'h00, 1'b0);
		send_hex_pair(8'hA0, 1'b0);
		send_event(EV_START, 8'h00);
		send_event(EV_MT_ACK, 8'h00);
		send_event(EV_REP_START, 8'h00);
		send_event(EV_MR_SLA_ACK, 8'h00);
		send_event(EV_MR_DATA, 8'hFF);
		send_event(EV_MR_LAST, 8'h00);
	endtask

	// Slave side, error events, and the codes the bridge takes no action on.
	task automatic test_slave_and_errors();
		send_event(EV_SLAVE_ADDR, 8'h12);
		send_event(EV_SLAVE_DATA, 8'h00);
		send_event(EV_SLAVE_DATA, 8'hFF);
		send_event(EV_SLAVE_STOP, 8'h00);
		send_event(EV_BUS_ERROR, 8'h3C);
		send_event(EV_ARB_LOST, 8'hC3);
		send_event(EV_MR_SLA_NAK, 8'h81);
		send_event(EV_NO_EVENT, 8'h7E);
		send_event(4'd15, 8'hE7);
	endtask

	// Fills more bytes than the buffer holds so the fill count wraps, then
	// sends what the wrapped count leaves. All entries are written afterwards.
	task automatic test_buffer_wrap();
		int i;
		send_serial(CH_SPACE);
		send_hex_pair(8'h01, 1'b0);
		for (i = 0; i < 258; i++)
			send_hex_pair(8'($urandom), 1'b0);
		send_event(EV_START, 8'($urandom));
		send_event(EV_MT_ACK, 8'($urandom));
		send_event(EV_MT_ACK, 8'($urandom));
	endtask

	// A long read makes the byte position wrap past 255, so the last-byte
	// match with a length of three is met both before and after the wrap.
	task automatic test_index_wrap();
		int i;
		send_serial(CH_SPACE);
		send_hex_pair(8'h03, 1'b0);
		send_event(EV_REP_START, 8'($urandom));
		send_event(EV_MR_SLA_ACK, 8'($urandom));
		for (i = 0; i < 262; i++)
			send_event(EV_MR_DATA, 8'($urandom));
		send_event(EV_MR_LAST, 8'($urandom));
	endtask

	// One random transaction: mostly well-formed host writes, host reads and
	// slave transfers with random content, the rest arbitrary words.
	task automatic random_transaction();
		int pick;
		int n;
		int i;
		pick = $urandom_range(0, 9);
		if (pick < 4) begin
			n = $urandom_range(0, 5);
			send_serial(CH_SPACE);
			send_hex_pair(8'($urandom), 1'b1);
			for (i = 0; i < n; i++)
				send_hex_pair(8'($urandom), 1'b1);
			send_event(EV_START, 8'($urandom));
			for (i = 0; i <= n; i++)
				send_event(EV_MT_ACK, 8'($urandom));
		end else if (pick < 7) begin
			n = $urandom_range(1, 4);
			send_serial(CH_DOT);
			send_serial(CH_SPACE);
			send_hex_pair(8'($urandom_range(0, 4)), 1'b1);
			send_hex_pair(8'($urandom), 1'b1);
			send_event(EV_START, 8'($urandom));
			send_event(EV_MT_ACK, 8'($urandom));
			send_event(EV_MT_ACK, 8'($urandom));
			send_event(EV_REP_START, 8'($urandom));
			send_event(EV_MR_SLA_ACK, 8'($urandom));
			for (i = 1; i < n; i++)
				send_event(EV_MR_DATA, 8'($urandom));
			send_event(EV_MR_LAST, 8'($urandom));
		end else if (pick < 9) begin
			n = $urandom_range(0, 4);
			send_event(EV_SLAVE_ADDR, 8'($urandom));
			for (i = 0; i < n; i++)
				send_event(EV_SLAVE_DATA, 8'($urandom));
			send_event(EV_SLAVE_STOP, 8'($urandom));
		end else begin
			n = $urandom_range(1, 4);
			for (i = 0; i < n; i++)
				send_word(1'($urandom), 8'($urandom), 4'($urandom), 8'($urandom));
		end
	endtask

	// Random traffic with idling switched on and off per transaction.
	task automatic test_random_traffic();
		int first;
		first = words_sent;
		while (words_sent - first < 200) begin
			gaps_on   = $urandom_range(0, 3) != 0;
			stalls_on = $urandom_range(0, 3) != 0;
			random_transaction();
		end
	endtask

	// Closing stretch at full rate on both sides.
	task automatic test_full_rate();
		int first;
		first     = words_sent;
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		while (words_sent - first < 40)
			random_transaction();
	endtask

	initial begin
		in_valid  <= 1'b0;
		op        <= 1'b0;
		rx_byte   <= 8'd0;
		twi_event <= 4'd0;
		twi_data  <= 8'd0;
		arst_n    <= 1'b0;
		reset_bridge();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gaps_on   = 1'b1;
		stalls_on = 1'b1;
		test_write_command();
		test_read_command();
		test_slave_and_errors();
		test_buffer_wrap();
		test_index_wrap();
		test_random_traffic();
		test_full_rate();

		// All words taken: stop offering and let the outstanding results drain.
		in_valid <= 1'b0;
		while (awaited_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("tb: %0d input words sent, %0d result words checked", words_sent, results_seen);
		$display("tb: covered parser, master write/read, slave, errors, buffer and index wrap");
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/hs2i_pkg.sv
hdl/hs2i_step.sv
hdl/hs2i_outq.sv
hdl/hex_serial_to_i2c_bridge.sv
tb/sv/hex_serial_to_i2c_bridge_tb.sv
